// File: src/mis_pkg.sv
`default_nettype none

package mis_pkg;

  localparam int CAPACITY   = 64;
  localparam int VALUE_BITS = 64;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int RC_W       = 7;

  localparam logic [VALUE_BITS-1:0] VAL_MAX = {VALUE_BITS{1'b1}};

  // request commands
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // table edit chosen for one request
  typedef enum logic [2:0] {
    OP_NONE       = 3'd0,
    OP_GROW_LEFT  = 3'd1,  // range below the value takes it as new high
    OP_GROW_RIGHT = 3'd2,  // range above the value takes it as new low
    OP_JOIN       = 3'd3,  // value bridges two ranges
    OP_OPEN       = 3'd4   // new single-value range
  } op_e;

  // what a cell shows its neighbors
  typedef struct packed {
    logic                  lt;     // high bound below the value
    logic                  first;  // left end of the chain
    logic [VALUE_BITS-1:0] lo;
    logic [VALUE_BITS-1:0] hi;
  } nb_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                  cmp_en;
    logic                  upd_en;
    op_e                   op;
    logic [VALUE_BITS-1:0] v;
  } cell_ctl_t;

  // per-cell match report
  typedef struct packed {
    logic pres;
    logic radj;
    logic ladj;
  } hit_t;

endpackage

`default_nettype wire

// File: src/mis_if.sv
`default_nettype none

interface mis_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [63:0] value;

  modport source (output valid, cmd, value, input ready);
  modport sink   (input valid, cmd, value, output ready);
endinterface

interface mis_res_if;
  logic       valid;
  logic       ready;
  logic       present;
  logic       inserted;
  logic       full_res;
  logic [6:0] range_count;

  modport source (output valid, present, inserted, full_res, range_count, input ready);
  modport sink   (input valid, present, inserted, full_res, range_count, output ready);
endinterface

`default_nettype wire

// File: src/merging_interval_set_core.sv
// Merging interval set: a sorted table of up to CAPACITY disjoint closed
// ranges, held one range per cell in a chain. A request (cmd 0 insert,
// cmd 1 query) is taken only while the controller is idle and goes through
// four steps: accept, compare (every cell checks its range against the
// value), decide (the cells' match flags are OR-ed into one table edit) and
// update (every cell shifts, extends or keeps its range in the same cycle).
// The update step stalls while the previous result is still waiting in the
// output register. The result holds present, inserted, full_res and the range
// count after the request; a new request may be taken while that result is
// still waiting. Bits of value above VALUE_BITS are ignored, adjacency never
// wraps at zero or at the largest value, and an insert that needs a new range
// on a full table flags full_res and leaves the table as it was. No clearing
// pass: reset zeroes the range count but not the stored ranges.
`default_nettype none

module merging_interval_set_core import mis_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  mis_req_if.sink     in_i,
  mis_res_if.source   out_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CMP  = 4'b0010,
    ST_DEC  = 4'b0100,
    ST_UPD  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // request latched at accept
  logic                  cmd_q;
  logic [VALUE_BITS-1:0] v_q;

  logic [CNT_W-1:0] count_q, count_d;

  // decision
  op_e  op_q, op_d;
  logic pres_q, ins_q, full_q;
  logic ins_d, full_d;

  // result register
  logic            res_vld_q;
  logic            res_pres_q, res_ins_q, res_full_q;
  logic [RC_W-1:0] res_cnt_q;

  logic in_acc, out_free;

  // chain wiring
  nb_t       nb    [CAPACITY];
  nb_t       left  [CAPACITY];
  nb_t       right [CAPACITY];
  hit_t      hit   [CAPACITY];
  logic [CAPACITY-1:0] pres_v, radj_v, ladj_v, vld_v;
  cell_ctl_t ctl;

  logic any_pres, any_radj, any_ladj;

  assign in_acc   = in_i.valid & in_i.ready;
  assign out_free = ~res_vld_q | out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE);

  assign ctl = '{cmp_en: (state_q == ST_CMP),
                 upd_en: (state_q == ST_UPD) & out_free,
                 op:     op_q,
                 v:      v_q};

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    // slot is in use when it lies below the range count
    assign vld_v[k] = (CNT_W'(k) < count_q);

    if (k == 0) begin : g_first
      assign left[k] = '{lt: 1'b0, first: 1'b1, lo: '0, hi: '0};
    end else begin : g_mid
      assign left[k] = nb[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign right[k] = '{lt: 1'b0, first: 1'b0, lo: '0, hi: '0};
    end else begin : g_inner
      assign right[k] = nb[k+1];
    end

    mis_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .vld_i   (vld_v[k]),
      .left_i  (left[k]),
      .right_i (right[k]),
      .nb_o    (nb[k]),
      .hit_o   (hit[k])
    );

    assign pres_v[k] = hit[k].pres;
    assign radj_v[k] = hit[k].radj;
    assign ladj_v[k] = hit[k].ladj;
  end

  // at most one cell reports each flag
  assign any_pres = |pres_v;
  assign any_radj = |radj_v;
  assign any_ladj = |ladj_v;

  always_comb begin
    op_d   = OP_NONE;
    ins_d  = 1'b0;
    full_d = 1'b0;
    if (cmd_q == CMD_INSERT && !any_pres) begin
      ins_d = 1'b1;
      if (any_ladj && any_radj) begin
        op_d = OP_JOIN;
      end else if (any_ladj) begin
        op_d = OP_GROW_LEFT;
      end else if (any_radj) begin
        op_d = OP_GROW_RIGHT;
      end else if (count_q >= CNT_W'(CAPACITY)) begin
        ins_d  = 1'b0;
        full_d = 1'b1;
      end else begin
        op_d = OP_OPEN;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc)   state_d = ST_CMP;
      ST_CMP:                state_d = ST_DEC;
      ST_DEC:                state_d = ST_UPD;
      ST_UPD:  if (out_free) state_d = ST_IDLE;
      default:               state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (state_q == ST_UPD && out_free) begin
      case (op_q)
        OP_JOIN: count_d = count_q - CNT_W'(1);
        OP_OPEN: count_d = count_q + CNT_W'(1);
        default: count_d = count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (state_q == ST_UPD && out_free) begin
        res_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= in_i.cmd;
      v_q   <= in_i.value[VALUE_BITS-1:0];
    end
    if (state_q == ST_DEC) begin
      op_q   <= op_d;
      pres_q <= any_pres;
      ins_q  <= ins_d;
      full_q <= full_d;
    end
    if (state_q == ST_UPD && out_free) begin
      res_pres_q <= pres_q;
      res_ins_q  <= ins_q;
      res_full_q <= full_q;
      res_cnt_q  <= RC_W'(count_d);
    end
  end

  assign out_o.valid       = res_vld_q;
  assign out_o.present     = res_pres_q;
  assign out_o.inserted    = res_ins_q;
  assign out_o.full_res    = res_full_q;
  assign out_o.range_count = res_cnt_q;

  // range count stays within the table
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("range count above capacity");

  // the range count only changes in the update step
  a_count_when: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> ($past(state_q) == ST_UPD))
    else $error("range count changed outside update");

  // a result never reports an insert together with present or full
  a_res_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.inserted && (out_o.present || out_o.full_res)))
    else $error("conflicting result flags");

  // full is only reported on a full table
  a_full_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.full_res) |-> (out_o.range_count == RC_W'(CAPACITY)))
    else $error("full reported below capacity");

endmodule

`default_nettype wire

// File: src/mis_cell.sv
`default_nettype none

// One table slot: holds one range, compares it against the broadcast value
// and takes its new contents from itself or a neighbor on update.
module mis_cell import mis_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  logic      vld_i,
  input  nb_t       left_i,
  input  nb_t       right_i,
  output nb_t       nb_o,
  output hit_t      hit_o
);

  logic [VALUE_BITS-1:0] lo_q, hi_q;
  logic lt_q, le_q, ra_q, la_q;
  logic ge_b, is_b, is_bm1;

  // boundary = first slot whose high bound is not below the value;
  // ge_b marks this slot at or past the boundary
  assign ge_b   = ~lt_q;
  assign is_b   = ~lt_q & (left_i.lt | left_i.first);
  assign is_bm1 = lt_q & ~right_i.lt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      le_q <= 1'b0;
      ra_q <= 1'b0;
      la_q <= 1'b0;
    end else if (ctl_i.cmp_en) begin
      lt_q <= vld_i & (hi_q < ctl_i.v);
      le_q <= vld_i & (lo_q <= ctl_i.v);
      ra_q <= vld_i & (ctl_i.v != VAL_MAX) & ((ctl_i.v + VALUE_BITS'(1)) == lo_q);
      la_q <= vld_i & (hi_q != VAL_MAX) & ((hi_q + VALUE_BITS'(1)) == ctl_i.v);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.upd_en) begin
      case (ctl_i.op)
        OP_GROW_LEFT: begin
          if (is_bm1) hi_q <= ctl_i.v;
        end
        OP_GROW_RIGHT: begin
          if (is_b) lo_q <= ctl_i.v;
        end
        OP_JOIN: begin
          if (is_bm1) begin
            hi_q <= right_i.hi;
          end else if (ge_b) begin
            lo_q <= right_i.lo;
            hi_q <= right_i.hi;
          end
        end
        OP_OPEN: begin
          if (is_b) begin
            lo_q <= ctl_i.v;
            hi_q <= ctl_i.v;
          end else if (ge_b) begin
            lo_q <= left_i.lo;
            hi_q <= left_i.hi;
          end
        end
        default: ;
      endcase
    end
  end

  assign nb_o  = '{lt: lt_q, first: 1'b0, lo: lo_q, hi: hi_q};
  assign hit_o = '{pres: is_b & le_q, radj: is_b & ra_q, ladj: is_bm1 & la_q};

endmodule

`default_nettype wire
